// File: sv/meu_pkg.sv
// ---------------------------------------------------------------------------
// meu_pkg: shared types and constants of the modular exponentiation unit
// Transaction structs, sequencer states and the bit-serial multiplier
// request shared by the top level and the multiplier.
// ---------------------------------------------------------------------------
package meu_pkg;

  // Fixed field widths of a transaction
  localparam int BASE_W = 63;
  localparam int EXPO_W = 63;
  localparam int MODI_W = 32;
  localparam int RES_W  = 32;

  // Default widths actually used for the modulus and the exponent
  localparam int MOD_WIDTH_DEF = 32;
  localparam int EXP_WIDTH_DEF = 63;

  // Serial operand length counter: holds up to BASE_W
  localparam int CNT_W = $clog2(BASE_W + 1);

  typedef struct packed {
    logic [BASE_W-1:0] base_value;
    logic [EXPO_W-1:0] exponent_value;
    logic [MODI_W-1:0] modulus_value;
  } meu_in_t;

  typedef struct packed {
    logic [RES_W-1:0] power_result;
    logic             modulus_error;
  } meu_out_t;

  // Request to the bit-serial modular multiplier
  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] nbits;
  } meu_mm_req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RED,
    S_SQ_GO,
    S_SQ,
    S_MU_GO,
    S_MU,
    S_OUT
  } meu_state_t;

endpackage

// File: sv/meu_modmul.sv
// ---------------------------------------------------------------------------
// meu_modmul: bit-serial modular multiplier
// Computes a * b mod m, scanning b MSB first one bit per cycle with an
// interleaved double-and-add and a reduction after each half step.
// ---------------------------------------------------------------------------
module meu_modmul
  import meu_pkg::*;
#(
  parameter int MOD_WIDTH = MOD_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  meu_mm_req_t          req,
  input  logic [MOD_WIDTH-1:0] a,
  input  logic [BASE_W-1:0]    b,
  input  logic [MOD_WIDTH-1:0] m,
  output logic                 done,
  output logic [MOD_WIDTH-1:0] r
);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [BASE_W-1:0]    sr;
  logic [MOD_WIDTH-1:0] a_r;
  logic [MOD_WIDTH-1:0] m_r;

  logic [MOD_WIDTH:0]   dbl;
  logic [MOD_WIDTH:0]   dbl_red;
  logic [MOD_WIDTH:0]   sum;
  logic [MOD_WIDTH:0]   sum_red;
  logic [MOD_WIDTH-1:0] r_next;

  // Double, reduce, conditionally add the multiplicand, reduce again
  always_comb begin
    dbl     = {r, 1'b0};
    dbl_red = (dbl >= {1'b0, m_r}) ? dbl - {1'b0, m_r} : dbl;
    sum     = {1'b0, dbl_red[MOD_WIDTH-1:0]} +
              (sr[BASE_W-1] ? {1'b0, a_r} : '0);
    sum_red = (sum >= {1'b0, m_r}) ? sum - {1'b0, m_r} : sum;
    r_next  = sum_red[MOD_WIDTH-1:0];
  end

  // Control: load on request, count bits, pulse done after the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath: operands and running remainder
  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt <= req.nbits;
      sr  <= b;
      a_r <= a;
      m_r <= m;
      r   <= '0;
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      sr  <= {sr[BASE_W-2:0], 1'b0};
      r   <= r_next;
    end
  end

endmodule

// File: sv/modular_exponentiation_unit.sv
// ---------------------------------------------------------------------------
// modular_exponentiation_unit: base^exponent mod modulus, square and multiply
// A zero modulus or zero exponent goes straight to the output state; otherwise
//   the base is reduced first, then the squares and multiplies follow
//   (EXP_WIDTH squares, one multiply per set exponent bit), all on the
//   single bit-serial multiplier, and then the output state.
// One transaction at a time; busy is high until the result
//   strobe, as the single bit-serial multiplier serves every step. The receiver
//   cannot stall. Synchronous active-high reset returns to idle.
// ---------------------------------------------------------------------------
module modular_exponentiation_unit
  import meu_pkg::*;
#(
  parameter int MOD_WIDTH = MOD_WIDTH_DEF,
  parameter int EXP_WIDTH = EXP_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  meu_in_t  operands,
  output logic     done,
  output meu_out_t result
);

  localparam int BIT_W = (EXP_WIDTH > 1) ? $clog2(EXP_WIDTH) : 1;

  meu_state_t state;
  meu_state_t state_next;

  logic [EXP_WIDTH-1:0] exp_sr;
  logic [BIT_W-1:0]     bit_cnt;
  logic [MOD_WIDTH-1:0] mod_r;
  logic [MOD_WIDTH-1:0] one_mod;
  logic [MOD_WIDTH-1:0] base_r;
  logic [MOD_WIDTH-1:0] acc;
  logic                 err_r;

  logic                 accept;
  logic [MOD_WIDTH-1:0] mod_in;
  logic [EXP_WIDTH-1:0] exp_in;
  logic [MOD_WIDTH-1:0] one_in;
  logic                 last_bit;

  meu_mm_req_t          mm_req;
  logic [MOD_WIDTH-1:0] mm_a;
  logic [BASE_W-1:0]    mm_b;
  logic [MOD_WIDTH-1:0] mm_m;
  logic                 mm_done;
  logic [MOD_WIDTH-1:0] mm_r;

  assign accept   = start && !busy;
  assign mod_in   = operands.modulus_value[MOD_WIDTH-1:0];
  assign exp_in   = operands.exponent_value[EXP_WIDTH-1:0];
  assign one_in   = (mod_in == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);
  assign last_bit = (bit_cnt == '0);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (mod_in == '0 || exp_in == '0) state_next = S_OUT;
          else                              state_next = S_RED;
        end
      end
      S_RED:   if (mm_done) state_next = S_SQ_GO;
      S_SQ_GO: state_next = S_SQ;
      S_SQ: begin
        if (mm_done) begin
          if (exp_sr[EXP_WIDTH-1]) state_next = S_MU_GO;
          else if (last_bit)       state_next = S_OUT;
          else                     state_next = S_SQ_GO;
        end
      end
      S_MU_GO: state_next = S_MU;
      S_MU: begin
        if (mm_done) state_next = last_bit ? S_OUT : S_SQ_GO;
      end
      S_OUT:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs: multiplier requests and handshake
  always_comb begin
    mm_req.start = 1'b0;
    mm_req.nbits = CNT_W'(MOD_WIDTH);
    mm_a         = acc;
    mm_b         = {acc, {(BASE_W-MOD_WIDTH){1'b0}}};
    mm_m         = mod_r;
    busy         = (state != S_IDLE);
    done         = (state == S_OUT);
    unique case (state)
      S_IDLE: begin
        // reduce the base as 1 * base mod m
        mm_req.start = accept && mod_in != '0 && exp_in != '0;
        mm_req.nbits = CNT_W'(BASE_W);
        mm_a         = one_in;
        mm_b         = operands.base_value;
        mm_m         = mod_in;
      end
      S_SQ_GO: mm_req.start = 1'b1;
      S_MU_GO: begin
        mm_req.start = 1'b1;
        mm_a         = base_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Datapath: capture the transaction, collect products, walk the exponent
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          exp_sr  <= exp_in;
          bit_cnt <= BIT_W'(EXP_WIDTH - 1);
          mod_r   <= mod_in;
          one_mod <= one_in;
          err_r   <= (mod_in == '0);
          acc     <= (mod_in == '0) ? '0 : MOD_WIDTH'(1);
        end
      end
      S_RED: begin
        if (mm_done) begin
          base_r <= mm_r;
          acc    <= one_mod;
        end
      end
      S_SQ: begin
        if (mm_done) begin
          acc <= mm_r;
          if (!exp_sr[EXP_WIDTH-1] && !last_bit) begin
            exp_sr  <= {exp_sr[EXP_WIDTH-2:0], 1'b0};
            bit_cnt <= bit_cnt - BIT_W'(1);
          end
        end
      end
      S_MU: begin
        if (mm_done) begin
          acc <= mm_r;
          if (!last_bit) begin
            exp_sr  <= {exp_sr[EXP_WIDTH-2:0], 1'b0};
            bit_cnt <= bit_cnt - BIT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign result.power_result  = RES_W'(acc);
  assign result.modulus_error = err_r;

  meu_modmul #(
    .MOD_WIDTH(MOD_WIDTH)
  ) u_modmul (
    .clk (clk),
    .rst (rst),
    .req (mm_req),
    .a   (mm_a),
    .b   (mm_b),
    .m   (mm_m),
    .done(mm_done),
    .r   (mm_r)
  );

`ifndef ASSERT_OFF
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("busy not raised after an accepted transaction");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.modulus_error) |-> result.power_result == '0)
    else $error("modulus error with nonzero result");

  a_mm_done_state: assert property (@(posedge clk) disable iff (rst)
    mm_done |-> (state == S_RED || state == S_SQ || state == S_MU))
    else $error("multiplier finished outside a wait state");

  a_req_idle_mm: assert property (@(posedge clk) disable iff (rst)
    mm_req.start |-> !mm_done)
    else $error("multiplier started while reporting a result");
`endif

endmodule
